>>> hdl/rhcc_pkg.sv
// ----------------------------------------------------------------------------
// rhcc_pkg: shared types and constants of the rolling hash chunk cutter
// Field widths, request codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package rhcc_pkg;

  localparam int TYPE_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int HASH_W  = 32;
  localparam int LEN_W   = 25;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 32;
  localparam int TAB_DEPTH = 1 << BYTE_W;

  localparam int WINDOW_LEN_DEF = 64;

  // request codes
  localparam logic [TYPE_W-1:0] REQ_TABLE = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_DATA  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_EOF   = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_MIN  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_MASK = 2'd2;

  localparam logic [LEN_W-1:0]  MIN_RESET  = LEN_W'(1 << 16);
  localparam logic [LEN_W-1:0]  MAX_RESET  = LEN_W'(1 << 23);
  localparam logic [HASH_W-1:0] MASK_RESET = HASH_W'((1 << 20) - 1);

  // request held between table read and hash update
  typedef struct packed {
    logic              valid;
    logic              is_data;
    logic              full;
    logic [BYTE_W-1:0] data_byte;
  } stage_t;

endpackage

>>> hdl/rhcc_cell.sv
// ----------------------------------------------------------------------------
// rhcc_cell: one byte of the hash window
// Loads the byte of its upstream neighbor on every shift.
// ----------------------------------------------------------------------------
module rhcc_cell (
  input  logic                       clk,
  input  logic                       shift,
  input  logic [rhcc_pkg::BYTE_W-1:0] d,
  output logic [rhcc_pkg::BYTE_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

>>> hdl/rhcc_window.sv
// ----------------------------------------------------------------------------
// rhcc_window: sliding byte window as a chain of cells
// New byte enters cell 0; the last cell holds the byte about to depart.
// ----------------------------------------------------------------------------
module rhcc_window #(
  parameter int WINDOW_LEN = rhcc_pkg::WINDOW_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        shift,
  input  logic                        clear,
  input  logic [rhcc_pkg::BYTE_W-1:0] in_byte,
  output logic [rhcc_pkg::BYTE_W-1:0] old_byte,
  output logic                        full
);

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_LEN);

  logic [rhcc_pkg::BYTE_W-1:0] taps [WINDOW_LEN+1];
  logic [FILL_W-1:0]           fill;

  assign taps[0] = in_byte;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    rhcc_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (taps[i]),
      .q     (taps[i+1])
    );
  end

  assign old_byte = taps[WINDOW_LEN];
  assign full     = (fill == FILL_MAX);

  // cell contents only matter once the window is full, so only fill resets
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
    end else if (shift && !full) begin
      fill <= fill + FILL_W'(1);
    end
  end

endmodule

>>> hdl/rhcc_table.sv
// ----------------------------------------------------------------------------
// rhcc_table: 256-word hash table
// One write port, two registered read ports (entering and departing byte).
// ----------------------------------------------------------------------------
module rhcc_table (
  input  logic                        clk,
  input  logic                        we,
  input  logic [rhcc_pkg::BYTE_W-1:0] waddr,
  input  logic [rhcc_pkg::HASH_W-1:0] wdata,
  input  logic                        re,
  input  logic [rhcc_pkg::BYTE_W-1:0] raddr_a,
  input  logic [rhcc_pkg::BYTE_W-1:0] raddr_b,
  output logic [rhcc_pkg::HASH_W-1:0] rdata_a,
  output logic [rhcc_pkg::HASH_W-1:0] rdata_b
);

  logic [rhcc_pkg::HASH_W-1:0] mem [rhcc_pkg::TAB_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> hdl/rhcc_hash.sv
// ----------------------------------------------------------------------------
// rhcc_hash: buzhash update, cut decision and result register
// Rolls the hash, counts the chunk length and holds one result.
// ----------------------------------------------------------------------------
module rhcc_hash #(
  parameter int WINDOW_LEN = rhcc_pkg::WINDOW_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rhcc_pkg::stage_t            stage,
  input  logic [rhcc_pkg::HASH_W-1:0] t_new,
  input  logic [rhcc_pkg::HASH_W-1:0] t_old,
  input  logic [rhcc_pkg::LEN_W-1:0]  min_chunk,
  input  logic [rhcc_pkg::LEN_W-1:0]  max_chunk,
  input  logic [rhcc_pkg::HASH_W-1:0] cut_mask,
  output logic                        go,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        byte_valid,
  output logic [rhcc_pkg::BYTE_W-1:0] out_byte,
  output logic                        chunk_end,
  output logic [rhcc_pkg::LEN_W-1:0]  chunk_length
);

  localparam int ROT = WINDOW_LEN % rhcc_pkg::HASH_W;

  logic [rhcc_pkg::HASH_W-1:0]   hash;
  logic [rhcc_pkg::LEN_W-1:0]    length;
  logic [2*rhcc_pkg::HASH_W-1:0] old_dbl;
  logic [rhcc_pkg::HASH_W-1:0]   old_rot;
  logic [rhcc_pkg::HASH_W-1:0]   hash_next;
  logic [rhcc_pkg::LEN_W-1:0]    len_inc;
  logic                          can_load;
  logic                          cut;

  assign can_load = !out_valid || out_ready;
  assign go       = stage.valid && can_load;

  // constant rotate of the departing word
  assign old_dbl = {t_old, t_old} << ROT;
  assign old_rot = old_dbl[2*rhcc_pkg::HASH_W-1:rhcc_pkg::HASH_W];

  assign hash_next = {hash[rhcc_pkg::HASH_W-2:0], hash[rhcc_pkg::HASH_W-1]} ^ t_new
                     ^ (stage.full ? old_rot : '0);
  assign len_inc   = length + rhcc_pkg::LEN_W'(1);
  assign cut       = (len_inc >= min_chunk) &&
                     (((hash_next & cut_mask) == '0) || (len_inc >= max_chunk));

  always_ff @(posedge clk) begin
    if (rst) begin
      hash      <= '0;
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (can_load) begin
        out_valid <= go && (stage.is_data || (length != '0));
      end
      if (go) begin
        if (stage.is_data) begin
          hash   <= hash_next;
          length <= cut ? '0 : len_inc;
        end else begin
          hash   <= '0;
          length <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      byte_valid   <= stage.is_data;
      out_byte     <= stage.is_data ? stage.data_byte : '0;
      chunk_end    <= stage.is_data ? cut : 1'b1;
      chunk_length <= stage.is_data ? len_inc : length;
    end
  end

endmodule

>>> hdl/rolling_hash_chunk_cutter_top.sv
// ----------------------------------------------------------------------------
// rolling_hash_chunk_cutter_top: content-defined chunker, buzhash over a window
// Channel   Handshake            Payload
// in        in_valid/in_ready    req_type, table_index, table_word, in_byte
// out       out_valid/out_ready  byte_valid, out_byte, chunk_end, chunk_length
// cfg       cfg_write            cfg_index, cfg_data
//
// One request per cycle while in_ready is high. A data byte or end of file
// reaches the output through the stage register, loaded with the table read
// at acceptance, then the hash update into the result register. Table writes
// and empty end of file give no result.
// Synchronous reset clears hash, length, window fill and handshake state;
// the table is undefined until written. A held result stalls the pipeline
// only once the request behind it is waiting too.
// ----------------------------------------------------------------------------
module rolling_hash_chunk_cutter_top #(
  parameter int WINDOW_LEN = rhcc_pkg::WINDOW_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [rhcc_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [rhcc_pkg::CDATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rhcc_pkg::TYPE_W-1:0]  req_type,
  input  logic [rhcc_pkg::BYTE_W-1:0]  table_index,
  input  logic [rhcc_pkg::HASH_W-1:0]  table_word,
  input  logic [rhcc_pkg::BYTE_W-1:0]  in_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         byte_valid,
  output logic [rhcc_pkg::BYTE_W-1:0]  out_byte,
  output logic                         chunk_end,
  output logic [rhcc_pkg::LEN_W-1:0]   chunk_length
);

  logic [rhcc_pkg::LEN_W-1:0]  min_chunk;
  logic [rhcc_pkg::LEN_W-1:0]  max_chunk;
  logic [rhcc_pkg::HASH_W-1:0] cut_mask;

  rhcc_pkg::stage_t            stage;
  logic                        go;
  logic                        accept;
  logic                        is_table;
  logic                        is_data;
  logic                        is_eof;
  logic [rhcc_pkg::BYTE_W-1:0] old_byte;
  logic                        full;
  logic [rhcc_pkg::HASH_W-1:0] t_new;
  logic [rhcc_pkg::HASH_W-1:0] t_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_chunk <= rhcc_pkg::MIN_RESET;
      max_chunk <= rhcc_pkg::MAX_RESET;
      cut_mask  <= rhcc_pkg::MASK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rhcc_pkg::CFG_MIN:  min_chunk <= cfg_data[rhcc_pkg::LEN_W-1:0];
        rhcc_pkg::CFG_MAX:  max_chunk <= cfg_data[rhcc_pkg::LEN_W-1:0];
        rhcc_pkg::CFG_MASK: cut_mask  <= cfg_data[rhcc_pkg::HASH_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !stage.valid || go;
  assign accept   = in_valid && in_ready;
  assign is_table = (req_type == rhcc_pkg::REQ_TABLE);
  assign is_data  = (req_type == rhcc_pkg::REQ_DATA);
  assign is_eof   = (req_type == rhcc_pkg::REQ_EOF);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (accept && (is_data || is_eof)) begin
      stage.valid <= 1'b1;
    end else if (go) begin
      stage.valid <= 1'b0;
    end
    if (accept) begin
      stage.is_data   <= is_data;
      stage.full      <= full;
      stage.data_byte <= in_byte;
    end
  end

  rhcc_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .shift    (accept && is_data),
    .clear    (accept && is_eof),
    .in_byte  (in_byte),
    .old_byte (old_byte),
    .full     (full)
  );

  rhcc_table u_table (
    .clk     (clk),
    .we      (accept && is_table),
    .waddr   (table_index),
    .wdata   (table_word),
    .re      (accept && is_data),
    .raddr_a (in_byte),
    .raddr_b (old_byte),
    .rdata_a (t_new),
    .rdata_b (t_old)
  );

  rhcc_hash #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_hash (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .t_new        (t_new),
    .t_old        (t_old),
    .min_chunk    (min_chunk),
    .max_chunk    (max_chunk),
    .cut_mask     (cut_mask),
    .go           (go),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .byte_valid   (byte_valid),
    .out_byte     (out_byte),
    .chunk_end    (chunk_end),
    .chunk_length (chunk_length)
  );

endmodule
